@@ rtl/core/prtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prtc_pkg
// Shared types and fixed-point constants of the Planck temperature converter.
// ----------------------------------------------------------------------------
package prtc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PLANCK_R   = 3'd0,
        CFG_PLANCK_B   = 3'd1,
        CFG_PLANCK_F   = 3'd2,
        CFG_PLANCK_O   = 3'd3,
        CFG_EMISSIVITY = 3'd4
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_NORMAL    = 2'd0,
        ST_NONPOS    = 2'd1,
        ST_CLAMPED   = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    localparam int Q30_FRAC = 30;              // fraction bits of ratio and log
    localparam int RATIO_W  = 63;              // ratio, 30 fraction bits
    localparam int LOG_W    = 36;              // log2 / ln result, 30 fraction bits
    localparam int LIM_W    = 35;              // clamp limit
    localparam int INT_W    = 6;               // integer part of log2

    localparam logic [30:0] SAFE_Q30 = 31'd1073956572;   // 1.0002 in Q30
    localparam logic [25:0] LN2_Q26  = 26'd46516320;     // ln(2) in Q26
    localparam logic [23:0] F_ONE    = 24'd1048576;      // 1.0 in Q20
    localparam logic [19:0] TEMP_MAX = 20'hFFFFF;

endpackage
`default_nettype wire

@@ rtl/core/planck_rbfo_temperature_convert_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planck_rbfo_temperature_convert_unit
// Converts a radiometric pixel signal to Kelvin through the Planck RBFO law.
// ----------------------------------------------------------------------------
// A new pixel request is taken on every clock (busy stays low) and its result
// appears with o_valid in request order. Each result passes through the three
// bit-per-stage divider pipelines (S/e, R/objsig, B/ln), the 32-stage log2
// pipeline and the registers between them. The receiver cannot stall; results
// must be taken when shown.
// Configuration writes are accepted at any time (o_cfg_ready high) but must
// only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module planck_rbfo_temperature_convert_unit #(
    parameter int PIXEL_BITS     = 16,
    parameter int TEMP_FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_pixel_signal,
    output logic             o_valid,
    output logic [19:0]      o_temp_kelvin,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import prtc_pkg::*;

    localparam int Q_W   = PIXEL_BITS + 23;     // S/e quotient
    localparam int OBJ_W = PIXEL_BITS + 25;     // signed object signal
    localparam int D2_W  = PIXEL_BITS + 24;     // positive object signal
    localparam int N2_W  = 62;                  // R << 30
    localparam int N3_W  = 46 + TEMP_FRAC_BITS; // B << (22 + frac)

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    logic [31:0] r_planck_r;
    logic [23:0] r_planck_b;
    logic [23:0] r_planck_f;
    logic [31:0] r_planck_o;
    logic [15:0] r_emissivity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planck_r   <= '0;
            r_planck_b   <= '0;
            r_planck_f   <= F_ONE;
            r_planck_o   <= '0;
            r_emissivity <= 16'd32768;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PLANCK_R:   r_planck_r   <= i_cfg_data;
                CFG_PLANCK_B:   r_planck_b   <= i_cfg_data[23:0];
                CFG_PLANCK_F:   r_planck_f   <= i_cfg_data[23:0];
                CFG_PLANCK_O:   r_planck_o   <= i_cfg_data;
                CFG_EMISSIVITY: r_emissivity <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Clamp limit, recomputed every cycle from F
    logic [54:0]      n_lim_prod;
    logic [LIM_W-1:0] r_lim;

    assign n_lim_prod = r_planck_f * SAFE_Q30;

    always_ff @(posedge i_clk) begin
        if (r_planck_f <= F_ONE) begin
            r_lim <= LIM_W'(SAFE_Q30);
        end else begin
            r_lim <= n_lim_prod[54:20];
        end
    end

    // Divide S by emissivity (zero treated as the smallest code)
    logic            d1_valid;
    logic [Q_W-1:0]  d1_quot;
    logic            d1_side;
    logic [15:0]     n_emis;

    assign n_emis = (r_emissivity == '0) ? 16'd1 : r_emissivity;

    prtc_div #(
        .NUM_W (Q_W),
        .DEN_W (16),
        .SIDE_W(1)
    ) u_div_emis (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(start),
        .i_num  ({i_pixel_signal[PIXEL_BITS-1:0], 23'd0}),
        .i_den  (n_emis),
        .i_side (1'b0),
        .o_valid(d1_valid),
        .o_quot (d1_quot),
        .o_side (d1_side)
    );

    // Subtract offset, flag a non-positive object signal
    logic [OBJ_W-1:0] n_obj;
    logic             n_nonpos;
    logic             r_a_v;
    logic [D2_W-1:0]  r_a_den;
    logic             r_a_nonpos;

    always_comb begin
        n_obj    = {2'b00, d1_quot}
                 - {{(OBJ_W-32){r_planck_o[31]}}, r_planck_o};
        n_nonpos = n_obj[OBJ_W-1] || (n_obj == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_den    <= n_nonpos ? D2_W'(1) : n_obj[D2_W-1:0];
        r_a_nonpos <= n_nonpos | d1_side;
    end

    // Divide R by the object signal
    logic            d2_valid;
    logic [N2_W-1:0] d2_quot;
    logic            d2_nonpos;

    prtc_div #(
        .NUM_W (N2_W),
        .DEN_W (D2_W),
        .SIDE_W(1)
    ) u_div_ratio (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_a_v),
        .i_num  ({r_planck_r, 30'd0}),
        .i_den  (r_a_den),
        .i_side (r_a_nonpos),
        .o_valid(d2_valid),
        .o_quot (d2_quot),
        .o_side (d2_nonpos)
    );

    // Add F and clamp the ratio from below
    logic [RATIO_W-1:0] n_ratio;
    logic               n_clamp;
    logic               r_b_v;
    logic [RATIO_W-1:0] r_b_ratio;
    logic [1:0]         r_b_flags;   // {clamped, nonpos}

    always_comb begin
        n_ratio = {1'b0, d2_quot} + {29'd0, r_planck_f, 10'd0};
        n_clamp = (n_ratio < {28'd0, r_lim});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_ratio <= n_clamp ? {28'd0, r_lim} : n_ratio;
        r_b_flags <= {n_clamp, d2_nonpos};
    end

    // log2 of the ratio
    logic             lg_valid;
    logic [LOG_W-1:0] lg_log;
    logic [1:0]       lg_flags;

    prtc_log2 #(
        .SIDE_W(2)
    ) u_log2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_b_v),
        .i_x    (r_b_ratio),
        .i_side (r_b_flags),
        .o_valid(lg_valid),
        .o_log  (lg_log),
        .o_side (lg_flags)
    );

    // Scale log2 to natural log
    logic [LOG_W+25:0] n_ln_prod;
    logic              r_c_v;
    logic [LOG_W-1:0]  r_c_ln;
    logic [1:0]        r_c_flags;

    assign n_ln_prod = lg_log * LN2_Q26;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= lg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_ln    <= n_ln_prod[LOG_W+25:26];
        r_c_flags <= lg_flags;
    end

    // Divide B by ln
    logic             n_ln_zero;
    logic             d3_valid;
    logic [N3_W-1:0]  d3_quot;
    logic [2:0]       d3_flags;  // {ln_zero, clamped, nonpos}

    assign n_ln_zero = (r_c_ln == '0);

    prtc_div #(
        .NUM_W (N3_W),
        .DEN_W (LOG_W),
        .SIDE_W(3)
    ) u_div_temp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_c_v),
        .i_num  ({r_planck_b, (22 + TEMP_FRAC_BITS)'(0)}),
        .i_den  (n_ln_zero ? LOG_W'(1) : r_c_ln),
        .i_side ({n_ln_zero, r_c_flags}),
        .o_valid(d3_valid),
        .o_quot (d3_quot),
        .o_side (d3_flags)
    );

    // Saturate and form the status
    logic n_sat;

    assign n_sat = d3_flags[2] || (d3_quot > N3_W'(TEMP_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= d3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d3_flags[0]) begin
            o_temp_kelvin <= '0;
            o_status      <= ST_NONPOS;
        end else if (n_sat) begin
            o_temp_kelvin <= TEMP_MAX;
            o_status      <= ST_SATURATED;
        end else begin
            o_temp_kelvin <= d3_quot[19:0];
            o_status      <= d3_flags[1] ? ST_CLAMPED : ST_NORMAL;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/prtc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prtc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side-band word that travels alongside each request.
// ----------------------------------------------------------------------------
module prtc_div #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [NUM_W-1:0]       o_quot,
    output logic [SIDE_W-1:0]      o_side
);

    logic              r_v    [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_nq   [NUM_W];   // numerator bits shift out, quotient bits in
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              v_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [NUM_W-1:0]  nq_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              take;
        logic [DEN_W-1:0]  n_rem;
        logic [NUM_W-1:0]  n_nq;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign den_in  = i_den;
            assign nq_in   = i_num;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign nq_in   = r_nq[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down one numerator bit, subtract the divisor when it fits
        always_comb begin
            trial = {rem_in, nq_in[NUM_W-1]};
            diff  = trial - {1'b0, den_in};
            take  = (trial >= {1'b0, den_in});
            n_rem = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_nq  = {nq_in[NUM_W-2:0], take};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_nq[k]   <= n_nq;
            r_den[k]  <= den_in;
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quot  = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule
`default_nettype wire

@@ rtl/core/prtc_log2.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prtc_log2
// Pipelined base-2 logarithm of a Q30 value >= 1.0: leading-one search,
// normalize, then one squaring stage per fraction bit.
// ----------------------------------------------------------------------------
module prtc_log2 #(
    parameter int SIDE_W = 2
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [prtc_pkg::RATIO_W-1:0] i_x,
    input  wire logic [SIDE_W-1:0]      i_side,
    output logic                        o_valid,
    output logic [prtc_pkg::LOG_W-1:0]  o_log,
    output logic [SIDE_W-1:0]           o_side
);
    import prtc_pkg::*;

    localparam int M_W = Q30_FRAC + 1;

    // Stage 0: locate leading one
    logic                r_s0_v;
    logic [RATIO_W-1:0]  r_s0_x;
    logic [INT_W-1:0]    r_s0_sh;
    logic [SIDE_W-1:0]   r_s0_side;
    logic [INT_W-1:0]    n_sh;

    always_comb begin
        n_sh = '0;
        for (int i = 0; i <= RATIO_W - 1 - Q30_FRAC; i++) begin
            if (i_x[Q30_FRAC + i]) begin
                n_sh = INT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_x    <= i_x;
        r_s0_sh   <= n_sh;
        r_s0_side <= i_side;
    end

    // Stage 1: normalize mantissa into [1,2)
    logic                r_s1_v;
    logic [M_W-1:0]      r_s1_m;
    logic [INT_W-1:0]    r_s1_int;
    logic [SIDE_W-1:0]   r_s1_side;
    logic [RATIO_W-1:0]  n_shifted;

    assign n_shifted = r_s0_x >> r_s0_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_m    <= n_shifted[M_W-1:0];
        r_s1_int  <= r_s0_sh;
        r_s1_side <= r_s0_side;
    end

    // Squaring stages: one fraction bit each, MSB first
    logic                r_v    [Q30_FRAC];
    logic [M_W-1:0]      r_m    [Q30_FRAC];
    logic [Q30_FRAC-1:0] r_frac [Q30_FRAC];
    logic [INT_W-1:0]    r_int  [Q30_FRAC];
    logic [SIDE_W-1:0]   r_side [Q30_FRAC];

    for (genvar k = 0; k < Q30_FRAC; k++) begin : g_sq
        logic                v_in;
        logic [M_W-1:0]      m_in;
        logic [Q30_FRAC-1:0] frac_in;
        logic [INT_W-1:0]    int_in;
        logic [SIDE_W-1:0]   side_in;
        logic [2*M_W-1:0]    prod;
        logic [M_W:0]        msq;
        logic [M_W-1:0]      n_m;

        if (k == 0) begin : g_first
            assign v_in    = r_s1_v;
            assign m_in    = r_s1_m;
            assign frac_in = '0;
            assign int_in  = r_s1_int;
            assign side_in = r_s1_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign m_in    = r_m[k-1];
            assign frac_in = r_frac[k-1];
            assign int_in  = r_int[k-1];
            assign side_in = r_side[k-1];
        end

        // square, renormalize when the result reaches 2.0
        always_comb begin
            prod = m_in * m_in;
            msq  = prod[2*M_W-1:Q30_FRAC];
            n_m  = msq[M_W] ? msq[M_W:1] : msq[M_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_m[k]    <= n_m;
            r_frac[k] <= {frac_in[Q30_FRAC-2:0], msq[M_W]};
            r_int[k]  <= int_in;
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_v[Q30_FRAC-1];
    assign o_log   = {r_int[Q30_FRAC-1], r_frac[Q30_FRAC-1]};
    assign o_side  = r_side[Q30_FRAC-1];

endmodule
`default_nettype wire

@@ dv/planck_rbfo_temperature_convert_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planck_rbfo_temperature_convert_checker
// Watches the pixel, result and register channels of the temperature
// converter, computes the expected Kelvin value and status of each accepted
// pixel request and compares every result against the oldest one waiting.
// ----------------------------------------------------------------------------
module planck_rbfo_temperature_convert_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] i_pixel_signal,
    input  logic        o_valid,
    input  logic [19:0] o_temp_kelvin,
    input  logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import prtc_pkg::*;

    typedef struct packed {
        logic [19:0] kelvin;
        t_status     status;
    } t_temp_result;

    t_temp_result temp_queue[$];

    // Shadow copy of the calibration registers
    logic [31:0] cal_r;
    logic [23:0] cal_b;
    logic [23:0] cal_f;
    logic [31:0] cal_o;
    logic [15:0] cal_emis;

    int mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = temp_queue.size();

    // log2 of a Q30 value >= 1.0, Q30 result, by repeated squaring
    function automatic longint unsigned log2_of_ratio(longint unsigned x);
        int              msb;
        longint unsigned mant;
        longint unsigned acc;
        msb = 63;
        while (msb > 30 && x[msb] == 1'b0) msb--;
        acc  = longint'(msb - 30) << 30;
        mant = x >> (msb - 30);
        for (int i = 29; i >= 0; i--) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd2 << 30)) begin
                mant = mant >> 1;
                acc[i] = 1'b1;
            end
        end
        return acc;
    endfunction

    // Kelvin value and status of one pixel under the current calibration
    function automatic t_temp_result kelvin_of_pixel(logic [15:0] pix);
        t_temp_result    res;
        longint unsigned emis;
        longint unsigned scaled;
        longint          obj;
        longint unsigned ratio;
        longint unsigned lim;
        longint unsigned ln_val;
        longint unsigned kel;
        logic            clamped;
        emis    = (cal_emis == 16'd0) ? 64'd1 : 64'(cal_emis);
        scaled  = (64'(pix) << 23) / emis;
        obj     = longint'(scaled) - longint'(signed'(cal_o));
        clamped = 1'b0;
        if (obj <= 0) begin
            res.kelvin = '0;
            res.status = ST_NONPOS;
            return res;
        end
        ratio = (64'(cal_r) << 30) / unsigned'(obj) + (64'(cal_f) << 10);
        if (cal_f <= F_ONE) begin
            lim = 64'(SAFE_Q30);
        end else begin
            lim = (64'(cal_f) * 64'(SAFE_Q30)) >> 20;
        end
        if (ratio < lim) begin
            ratio   = lim;
            clamped = 1'b1;
        end
        ln_val = (log2_of_ratio(ratio) * 64'(LN2_Q26)) >> 26;
        if (ln_val == 0) begin
            res.kelvin = TEMP_MAX;
            res.status = ST_SATURATED;
            return res;
        end
        kel = (64'(cal_b) << 30) / ln_val;
        if (kel > 64'(TEMP_MAX)) begin
            res.kelvin = TEMP_MAX;
            res.status = ST_SATURATED;
        end else begin
            res.kelvin = kel[19:0];
            res.status = clamped ? ST_CLAMPED : ST_NORMAL;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_temp_result want;
        if (!i_rst_n) begin
            cal_r      <= '0;
            cal_b      <= '0;
            cal_f      <= F_ONE;
            cal_o      <= '0;
            cal_emis   <= 16'd32768;
            mismatches <= 0;
            temp_queue.delete();
        end else begin
            // Track register writes; unused indexes are dropped
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PLANCK_R:   cal_r    <= i_cfg_data;
                    CFG_PLANCK_B:   cal_b    <= i_cfg_data[23:0];
                    CFG_PLANCK_F:   cal_f    <= i_cfg_data[23:0];
                    CFG_PLANCK_O:   cal_o    <= i_cfg_data;
                    CFG_EMISSIVITY: cal_emis <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // Predict each accepted request
            if (start && !busy) temp_queue.push_back(kelvin_of_pixel(i_pixel_signal));
            // Compare each result with the oldest expectation
            if (o_valid) begin
                if (temp_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("ERROR: result with nothing expected: kelvin %0d status %0d",
                                 o_temp_kelvin, o_status);
                    mismatches <= mismatches + 1;
                end else begin
                    want = temp_queue.pop_front();
                    if (want.kelvin !== o_temp_kelvin || want.status !== o_status) begin
                        if (mismatches < 10)
                            $display("ERROR: expected kelvin %0d status %0d, got %0d status %0d",
                                     want.kelvin, want.status, o_temp_kelvin, o_status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

@@ dv/tb_planck_rbfo_temperature_convert_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planck_rbfo_temperature_convert_unit
// Drives pixel requests and calibration writes into the temperature converter
// over eight calibration phases with varying request gaps; the checker
// predicts and compares every result and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_planck_rbfo_temperature_convert_unit;
    import prtc_pkg::*;

    localparam int          LATENCY        = 191;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          PHASES         = 8;
    localparam int          PHASE_ITEMS    = 244;
    localparam logic [2:0]  CFG_UNUSED_IDX = 3'd5;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_pixel_signal;
    logic        o_valid;
    logic [19:0] o_temp_kelvin;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          sent;

    planck_rbfo_temperature_convert_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pixel_signal(i_pixel_signal),
        .o_valid       (o_valid),
        .o_temp_kelvin (o_temp_kelvin),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    planck_rbfo_temperature_convert_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pixel_signal(i_pixel_signal),
        .o_valid       (o_valid),
        .o_temp_kelvin (o_temp_kelvin),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("planck_rbfo_temperature_convert_unit test failed");
            $finish;
        end
    end

    // Write one calibration register, called at a falling edge
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_calibration(logic [31:0] r, logic [23:0] b, logic [23:0] f,
                                    logic [31:0] o, logic [15:0] emis);
        write_reg(CFG_PLANCK_R, r);
        write_reg(CFG_PLANCK_B, {8'h0, b});
        write_reg(CFG_PLANCK_F, {8'h0, f});
        write_reg(CFG_PLANCK_O, o);
        write_reg(CFG_EMISSIVITY, {16'h0, emis});
    endtask

    // Hold one pixel request until taken, then idle at random
    task automatic send_pixel(logic [15:0] pix, int idle_pct);
        start          = 1'b1;
        i_pixel_signal = pix;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // Let all results drain, then allow the pipeline to settle
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
    endtask

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 255));
            1:       return 16'($urandom_range(65280, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] edge_pix[8];
        int          idle_pct;
        sent           = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_pixel_signal = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PLANCK_R;
        i_cfg_data     = '0;
        edge_pix = '{16'h0000, 16'h0001, 16'h0002, 16'h7FFF,
                     16'h8000, 16'hFFFF, 16'hAAAA, 16'h5555};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset calibration: R and B zero, every ratio clamps
        foreach (edge_pix[k]) send_pixel(edge_pix[k], 0);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_calibration(32'h0FA0_0000, 24'h16_0000, 24'h10_0000, 32'h0, 16'd32768);
                1: load_calibration(32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                                    32'h7FFF_FFFF, 16'hFFFF);
                2: load_calibration(32'h0, 24'hFF_FFFF, 24'h0, 32'h8000_0000, 16'h0);
                3: begin
                    load_calibration(32'h1234_5678, 24'h3A_9800, 24'h10_0001,
                                     32'hFFFF_F000, 16'd1);
                    write_reg(CFG_UNUSED_IDX, 32'hDEAD_BEEF);
                end
                default: load_calibration($urandom, 24'($urandom), 24'($urandom_range(0, 4194304)),
                                          ($urandom_range(0, 1) == 1) ? $urandom
                                              : 32'($urandom_range(0, 65535)) - 32'd32768,
                                          16'($urandom_range(0, 65535)));
            endcase
            idle_pct = (ph < 3) ? 33 : (ph < 6) ? 77 : 0;
            foreach (edge_pix[k]) send_pixel(edge_pix[k], idle_pct);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel(random_pixel(), (n % 60 < 12) ? 0 : idle_pct);
                // Hold off until the pipeline is empty once
                if (ph == 4 && n == PHASE_ITEMS / 2) begin
                    start = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        $display("Covered %0d pixel requests over %0d calibrations, incl. edge and random settings.",
                 sent, PHASES + 1);
        $display("Gaps: 33%% and 77%% sender idling, back-to-back bursts, one full drain pause.");
        if (fail_count == 0 && pending == 0) begin
            $display("planck_rbfo_temperature_convert_unit test passed");
        end else begin
            $display("planck_rbfo_temperature_convert_unit test failed");
        end
        $finish;
    end

endmodule
